/* rtl/ssa_pkg.sv */
`timescale 1ns / 1ps

package ssa_pkg;

	// Fixed field widths of the command and request beats.
	localparam int CFG_W      = 11;
	localparam int SLOT_W     = 10;
	localparam int SECTOR_W   = 13;
	localparam int ADDR_W     = 32;

	// The bitmap is stored as words of this many slot bits.
	localparam int WORD_BITS  = 32;
	localparam int WORD_IDX_W = 5;

	// Reset value of the slot count register.
	localparam logic [CFG_W-1:0] SLOT_COUNT_RST = 11'd1024;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic {
		DIR_WRITE = 1'b0,
		DIR_READ  = 1'b1
	} dir_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SC_IDLE,
		SC_SCAN,
		SC_CHECK,
		SC_HAND
	} scan_state_t;

	// Command beat.
	typedef struct packed {
		cmd_t              cmd;
		logic [SLOT_W-1:0] slot;
		logic [ADDR_W-1:0] page_address;
	} ssa_in_t;

	// Sector request beat.
	typedef struct packed {
		status_t             status;
		dir_t                direction;
		logic [SLOT_W-1:0]   slot_num;
		logic [SECTOR_W-1:0] sector;
		logic [ADDR_W-1:0]   buffer_address;
		logic                last;
	} ssa_out_t;

	// Resolved command handed from the bitmap scanner to the request emitter.
	typedef struct packed {
		status_t             status;
		dir_t                direction;
		logic [SLOT_W-1:0]   slot_num;
		logic [SECTOR_W-1:0] sector;
		logic [ADDR_W-1:0]   page_address;
	} ssa_job_t;

endpackage

/* rtl/ssa_bitmap.sv */
`timescale 1ns / 1ps

module ssa_bitmap import ssa_pkg::*; #(
	parameter int MAX_SLOTS = 1024,
	localparam int WORDS    = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS,
	localparam int WW       = (WORDS > 1) ? $clog2(WORDS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [WW-1:0]        rd_addr,
	output logic [WORD_BITS-1:0] rd_data,
	input  logic                 wr_en,
	input  logic [WW-1:0]        wr_addr,
	input  logic [WORD_BITS-1:0] wr_data,
	output logic                 busy
);

	logic [WORD_BITS-1:0] mem [WORDS];
	logic [WORD_BITS-1:0] rd_data_q;
	logic [WW-1:0]        clr_q;
	logic                 busy_q;

	// After reset, one word per cycle is cleared until the whole bitmap is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (clr_q == WW'(WORDS - 1)) begin
				busy_q <= 1'b0;
			end else begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// Single write port, shared by the clearing pass and the update path.
	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = busy_q;

endmodule

/* rtl/ssa_scan.sv */
`timescale 1ns / 1ps

module ssa_scan import ssa_pkg::*; #(
	parameter int MAX_SLOTS        = 1024,
	parameter int SECTORS_PER_SLOT = 8,
	localparam int WORDS           = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS,
	localparam int WW              = (WORDS > 1) ? $clog2(WORDS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [CFG_W-1:0]     slot_count,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  ssa_in_t              in_data,
	output logic                 rd_en,
	output logic [WW-1:0]        rd_addr,
	input  logic [WORD_BITS-1:0] rd_data,
	output logic                 wr_en,
	output logic [WW-1:0]        wr_addr,
	output logic [WORD_BITS-1:0] wr_data,
	input  logic                 mem_busy,
	output logic                 job_valid,
	input  logic                 job_ready,
	output ssa_job_t             job
);

	localparam int SIW   = WW + WORD_IDX_W;
	localparam int LW    = (SIW + 1 > CFG_W) ? SIW + 1 : CFG_W;
	localparam int MW    = $clog2(SECTORS_PER_SLOT + 1);
	localparam int PW    = LW + MW;

	// Index of the lowest set bit of a bitmap word.
	function automatic logic [WORD_IDX_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
		logic [WORD_IDX_W-1:0] idx;
		idx = '0;
		for (int j = WORD_BITS - 1; j >= 0; j--) begin
			if (v[j]) begin
				idx = WORD_IDX_W'(j);
			end
		end
		return idx;
	endfunction

	scan_state_t          state_q, state_d;
	cmd_t                 cmd_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [ADDR_W-1:0]    page_q;
	logic [WW:0]          word_q;
	logic [WW:0]          hint_q;
	logic [WORD_BITS-1:0] mask_s1;
	ssa_job_t             job_q;

	logic [LW-1:0]         limit;
	logic [LW-1:0]         in_slot_ext;
	logic                  in_slot_ok;
	logic [WW:0]           in_word;
	logic [LW-1:0]         base;
	logic                  base_ok;
	logic [LW-1:0]         rem;
	logic [WORD_BITS-1:0]  mask;
	logic [WORD_BITS-1:0]  avail;
	logic                  found;
	logic [WORD_IDX_W-1:0] found_bit;
	logic [WORD_IDX_W-1:0] bit_sel;
	logic [WORD_BITS-1:0]  onehot;
	logic [LW-1:0]         free_slot_ext;
	logic [WW:0]           free_word;
	logic [LW-1:0]         sel_slot;
	logic [PW-1:0]         sector_prod;
	logic [WORD_BITS-1:0]  new_word;
	logic                  accept;

	// Slot count register values above the bitmap size act as the bitmap size.
	assign limit = (LW'(slot_count) > LW'(MAX_SLOTS)) ? LW'(MAX_SLOTS) : LW'(slot_count);

	// Range check and word address of a slot given with a free command.
	assign in_slot_ext   = LW'(in_data.slot);
	assign in_slot_ok    = in_slot_ext < limit;
	assign in_word       = (WW + 1)'(in_slot_ext >> WORD_IDX_W);
	assign free_slot_ext = LW'(slot_q);
	assign free_word     = (WW + 1)'(free_slot_ext >> WORD_IDX_W);

	// Slots of the current word that lie below the active slot count.
	assign base    = LW'(word_q) << WORD_IDX_W;
	assign base_ok = base < limit;
	assign rem     = limit - base;
	assign mask    = (rem >= LW'(WORD_BITS)) ? '1
		: ((WORD_BITS'(1) << rem[WORD_IDX_W-1:0]) - WORD_BITS'(1));

	// First free slot in the word just read.
	assign avail     = ~rd_data & mask_s1;
	assign found     = |avail;
	assign found_bit = lowest_set(avail);

	// Read-modify-write of the addressed bitmap word.
	assign bit_sel  = (cmd_q == CMD_ALLOC) ? found_bit : slot_q[WORD_IDX_W-1:0];
	assign onehot   = WORD_BITS'(1) << bit_sel;
	assign new_word = (cmd_q == CMD_ALLOC) ? (rd_data | onehot) : (rd_data & ~onehot);

	// First sector of the chosen slot.
	assign sel_slot    = (cmd_q == CMD_ALLOC)
		? ((LW'(word_q) << WORD_IDX_W) | LW'(found_bit)) : free_slot_ext;
	assign sector_prod = PW'(sel_slot) * PW'(SECTORS_PER_SLOT);

	assign accept = (state_q == SC_IDLE) && in_valid && !mem_busy;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			SC_IDLE: begin
				if (accept) begin
					state_d = (in_data.cmd == CMD_FREE && !in_slot_ok) ? SC_HAND : SC_SCAN;
				end
			end
			SC_SCAN: begin
				state_d = (cmd_q == CMD_ALLOC && !base_ok) ? SC_HAND : SC_CHECK;
			end
			SC_CHECK: begin
				state_d = (cmd_q == CMD_ALLOC && !found) ? SC_SCAN : SC_HAND;
			end
			SC_HAND: begin
				if (job_ready) begin
					state_d = SC_IDLE;
				end
			end
			default: begin
				state_d = SC_IDLE;
			end
		endcase
	end

	// Handshake and memory strobes.
	always_comb begin
		in_stall  = (state_q != SC_IDLE) || mem_busy;
		rd_en     = (state_q == SC_SCAN) && (cmd_q == CMD_FREE || base_ok);
		wr_en     = (state_q == SC_CHECK) && (cmd_q == CMD_FREE || found);
		job_valid = (state_q == SC_HAND);
	end

	assign rd_addr = word_q[WW-1:0];
	assign wr_addr = word_q[WW-1:0];
	assign wr_data = new_word;
	assign job     = job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Search hint: every word below it is completely used.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hint_q <= '0;
		end else if (state_q == SC_CHECK) begin
			if (cmd_q == CMD_ALLOC && found) begin
				hint_q <= (new_word == '1) ? word_q + 1'b1 : word_q;
			end else if (cmd_q == CMD_FREE && free_word < hint_q) begin
				hint_q <= free_word;
			end
		end
	end

	// Command capture, word walk and result build.
	always_ff @(posedge clk) begin
		case (state_q)
			SC_IDLE: begin
				if (accept) begin
					cmd_q  <= in_data.cmd;
					slot_q <= in_data.slot;
					page_q <= in_data.page_address;
					word_q <= (in_data.cmd == CMD_ALLOC) ? hint_q : in_word;
					job_q.status       <= ST_RANGE;
					job_q.direction    <= DIR_READ;
					job_q.slot_num     <= in_data.slot;
					job_q.sector       <= '0;
					job_q.page_address <= '0;
				end
			end
			SC_SCAN: begin
				mask_s1 <= mask;
				job_q.status       <= ST_FULL;
				job_q.direction    <= DIR_WRITE;
				job_q.slot_num     <= '0;
				job_q.sector       <= '0;
				job_q.page_address <= '0;
			end
			SC_CHECK: begin
				if (cmd_q == CMD_ALLOC && !found) begin
					word_q <= word_q + 1'b1;
				end else begin
					job_q.status       <= ST_OK;
					job_q.direction    <= (cmd_q == CMD_ALLOC) ? DIR_WRITE : DIR_READ;
					job_q.slot_num     <= sel_slot[SLOT_W-1:0];
					job_q.sector       <= sector_prod[SECTOR_W-1:0];
					job_q.page_address <= page_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

/* rtl/ssa_emit.sv */
`timescale 1ns / 1ps

module ssa_emit import ssa_pkg::*; #(
	parameter int SECTORS_PER_SLOT = 8,
	parameter int SECTOR_BYTES     = 512
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     job_valid,
	output logic     job_ready,
	input  ssa_job_t job,
	output logic     out_valid,
	input  logic     out_stall,
	output ssa_out_t out_data
);

	localparam int CW = (SECTORS_PER_SLOT > 1) ? $clog2(SECTORS_PER_SLOT) : 1;

	logic                busy_q;
	logic                out_valid_q;
	ssa_job_t            cur_q;
	logic [CW-1:0]       cnt_q;
	logic [SECTOR_W-1:0] sec_q;
	logic [ADDR_W-1:0]   addr_q;
	ssa_out_t            out_q;

	logic     load;
	logic     take_job;
	logic     beat_last;
	ssa_out_t beat;

	// The output register takes a new beat when empty or when its beat leaves.
	assign load     = !out_valid_q || !out_stall;
	assign take_job = job_valid && !busy_q;

	// Error results are a single beat; requests end after the slot's last sector.
	assign beat_last = (cur_q.status != ST_OK) || (cnt_q == CW'(SECTORS_PER_SLOT - 1));

	always_comb begin
		beat.status         = cur_q.status;
		beat.direction      = cur_q.direction;
		beat.slot_num       = cur_q.slot_num;
		beat.sector         = sec_q;
		beat.buffer_address = addr_q;
		beat.last           = beat_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take_job) begin
				busy_q <= 1'b1;
			end else if (busy_q && load && beat_last) begin
				busy_q <= 1'b0;
			end
			if (load) begin
				out_valid_q <= busy_q;
			end
		end
	end

	// Sector number and buffer address step once per beat.
	always_ff @(posedge clk) begin
		if (take_job) begin
			cur_q  <= job;
			cnt_q  <= '0;
			sec_q  <= job.sector;
			addr_q <= job.page_address;
		end else if (busy_q && load) begin
			out_q  <= beat;
			cnt_q  <= cnt_q + 1'b1;
			sec_q  <= sec_q + 1'b1;
			addr_q <= addr_q + ADDR_W'(SECTOR_BYTES);
		end
	end

	assign job_ready = !busy_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* rtl/swap_slot_allocator_top.sv */
// First-fit swap slot allocator.
// Command channel (in_valid, in_stall, in_data): cmd 0 takes the lowest free slot
// below the active slot count, marks it used and issues one sector write request
// per sector of the slot; cmd 1 issues sector read requests for the given slot and
// frees it. A full bitmap or an out-of-range slot gives a single error beat.
// Request channel (out_valid, out_stall, out_data): one beat per sector, last set on
// the final beat of a command. The buffer address steps by SECTOR_BYTES per beat.
// The slot count register is written through cfg_wr_en and cfg_wr_data; values
// above MAX_SLOTS act as MAX_SLOTS.
// Search: a free in range reads and rewrites the word that holds its slot; an
// allocate walks the bitmap one 32-slot word at a time from the search hint,
// reading each word in SC_SCAN and checking and rewriting it in SC_CHECK, as
// the bitmap's read port is registered. The next command is taken while the
// current one's beats drain.
// Reset clears the bitmap one word per cycle; in_stall stays high during that
// pass. When the receiver stalls, the current beat is held and emission pauses
// without loss.
`timescale 1ns / 1ps

module swap_slot_allocator_top import ssa_pkg::*; #(
	parameter int MAX_SLOTS        = 1024,
	parameter int SECTORS_PER_SLOT = 8,
	parameter int SECTOR_BYTES     = 512
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CFG_W-1:0] cfg_wr_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  ssa_in_t          in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output ssa_out_t         out_data
);

	localparam int WORDS = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
	localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;

	logic [CFG_W-1:0]     slot_count_q;
	logic                 rd_en;
	logic [WW-1:0]        rd_addr;
	logic [WORD_BITS-1:0] rd_data;
	logic                 wr_en;
	logic [WW-1:0]        wr_addr;
	logic [WORD_BITS-1:0] wr_data;
	logic                 mem_busy;
	logic                 job_valid;
	logic                 job_ready;
	ssa_job_t             job;

	// Slot count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= SLOT_COUNT_RST;
		end else if (cfg_wr_en) begin
			slot_count_q <= cfg_wr_data;
		end
	end

	ssa_bitmap #(
		.MAX_SLOTS(MAX_SLOTS)
	) u_bitmap (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.busy    (mem_busy)
	);

	ssa_scan #(
		.MAX_SLOTS        (MAX_SLOTS),
		.SECTORS_PER_SLOT (SECTORS_PER_SLOT)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.slot_count (slot_count_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.mem_busy   (mem_busy),
		.job_valid  (job_valid),
		.job_ready  (job_ready),
		.job        (job)
	);

	ssa_emit #(
		.SECTORS_PER_SLOT (SECTORS_PER_SLOT),
		.SECTOR_BYTES     (SECTOR_BYTES)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import ssa_pkg::*;

	localparam int MAX_SLOTS        = 1024;
	localparam int SECTORS_PER_SLOT = 8;
	localparam int SECTOR_BYTES     = 512;
	localparam int SETTLE_CYCLES    = 20;
	localparam int CYCLE_LIMIT      = 1000000;

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [CFG_W-1:0] cfg_wr_data;
	logic             in_valid;
	logic             in_stall;
	ssa_in_t          in_data;
	logic             out_valid;
	logic             out_stall;
	ssa_out_t         out_data;

	// Predictor state: slot bitmap, slot count register and the beats still owed.
	bit               slot_taken [MAX_SLOTS];
	logic [CFG_W-1:0] slot_count_reg;
	ssa_out_t         pending_requests [$];
	int unsigned      mismatch_count;
	bit               quiet;

	swap_slot_allocator_top #(
		.MAX_SLOTS(MAX_SLOTS),
		.SECTORS_PER_SLOT(SECTORS_PER_SLOT),
		.SECTOR_BYTES(SECTOR_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog: a run that does not finish in time has hung.
	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	// Idle length: mostly none or short, now and then long; always none while quiet is set.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 45)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	// The receiver stalls the request channel in random stretches.
	initial begin
		int unsigned n;
		out_stall = 1'b0;
		forever begin
			n = pick_gap();
			if (n > 0) begin
				@(negedge clk);
				out_stall <= 1'b1;
				repeat (n - 1) @(negedge clk);
			end
			n = $urandom_range(1, 8);
			@(negedge clk);
			out_stall <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	end

	function automatic int unsigned active_slots();
		return (slot_count_reg > MAX_SLOTS) ? MAX_SLOTS : slot_count_reg;
	endfunction

	// Queue one ok beat per sector of the slot.
	task automatic queue_sector_beats(input dir_t dir, input int unsigned slot,
			input logic [ADDR_W-1:0] page);
		ssa_out_t beat;
		for (int i = 0; i < SECTORS_PER_SLOT; i++) begin
			beat                = '0;
			beat.status         = ST_OK;
			beat.direction      = dir;
			beat.slot_num       = SLOT_W'(slot);
			beat.sector         = SECTOR_W'(slot * SECTORS_PER_SLOT + i);
			beat.buffer_address = page + ADDR_W'(i * SECTOR_BYTES);
			beat.last           = (i == SECTORS_PER_SLOT - 1);
			pending_requests.push_back(beat);
		end
	endtask

	// Work out the request beats of one accepted command and update the bitmap.
	task automatic predict_sector_requests(input ssa_in_t item);
		int unsigned limit;
		int unsigned s;
		ssa_out_t    beat;
		limit = active_slots();
		beat  = '0;
		beat.last = 1'b1;
		if (item.cmd == CMD_ALLOC) begin
			s = 0;
			while (s < limit && slot_taken[s])
				s++;
			if (s >= limit) begin
				beat.status    = ST_FULL;
				beat.direction = DIR_WRITE;
				pending_requests.push_back(beat);
			end else begin
				slot_taken[s] = 1'b1;
				queue_sector_beats(DIR_WRITE, s, item.page_address);
			end
		end else if (item.slot >= limit) begin
			beat.status     = ST_RANGE;
			beat.direction  = DIR_READ;
			beat.slot_num   = item.slot;
			pending_requests.push_back(beat);
		end else begin
			queue_sector_beats(DIR_READ, item.slot, item.page_address);
			slot_taken[item.slot] = 1'b0;
		end
	endtask

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	// Check every accepted request beat against the oldest expected one.
	always @(posedge clk) begin
		ssa_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_requests.size() == 0) begin
				report_mismatch($sformatf("unexpected beat %p", out_data));
			end else begin
				want = pending_requests.pop_front();
				if (out_data.status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						out_data.status, want.status));
				if (out_data.direction !== want.direction)
					report_mismatch($sformatf("direction %0d, expected %0d",
						out_data.direction, want.direction));
				if (out_data.slot_num !== want.slot_num)
					report_mismatch($sformatf("slot_num %0d, expected %0d",
						out_data.slot_num, want.slot_num));
				if (out_data.sector !== want.sector)
					report_mismatch($sformatf("sector %0d, expected %0d",
						out_data.sector, want.sector));
				if (out_data.buffer_address !== want.buffer_address)
					report_mismatch($sformatf("buffer_address %h, expected %h",
						out_data.buffer_address, want.buffer_address));
				if (out_data.last !== want.last)
					report_mismatch($sformatf("last %0d, expected %0d",
						out_data.last, want.last));
			end
		end
	end

	// Send one command beat after a random gap; predict once it is taken.
	task automatic send_command(input cmd_t cmd, input logic [SLOT_W-1:0] slot,
			input logic [ADDR_W-1:0] page);
		int unsigned gap;
		ssa_in_t     item;
		gap = pick_gap();
		item.cmd          = cmd;
		item.slot         = slot;
		item.page_address = page;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data  <= item;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		predict_sector_requests(item);
	endtask

	task automatic alloc_slot(input logic [ADDR_W-1:0] page);
		send_command(CMD_ALLOC, SLOT_W'($urandom), page);
	endtask

	task automatic free_slot(input logic [SLOT_W-1:0] slot, input logic [ADDR_W-1:0] page);
		send_command(CMD_FREE, slot, page);
	endtask

	// Stop sending and wait until every owed beat has arrived.
	task automatic drain_requests();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_requests.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_slot_count(input logic [CFG_W-1:0] value);
		drain_requests();
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		slot_count_reg = value;
	endtask

	// Page addresses lean toward zero, all ones and values that wrap.
	function automatic logic [ADDR_W-1:0] pick_page();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 32'hFFFF_FFFF - $urandom_range(0, 4095);
			default: return $urandom;
		endcase
	endfunction

	// A slot that is currently in use, or any slot when none is.
	function automatic logic [SLOT_W-1:0] pick_held_slot();
		int unsigned held [$];
		for (int s = 0; s < active_slots(); s++)
			if (slot_taken[s])
				held.push_back(s);
		if (held.size() == 0)
			return SLOT_W'($urandom);
		return SLOT_W'(held[$urandom_range(0, held.size() - 1)]);
	endfunction

	// Reset slot count: first fit, reuse of a freed slot, address wrap, free of a free slot.
	task automatic test_first_fit();
		alloc_slot(32'h0000_0000);
		alloc_slot(32'hFFFF_FFFF);
		alloc_slot(32'hFFFF_F000);
		free_slot(10'd1023, 32'hFFFF_FE00);
		free_slot(10'd0, 32'h1234_5678);
		alloc_slot(32'h8000_0000);
		free_slot(10'd1, 32'h0000_0000);
	endtask

	// Two slots: the bitmap fills up and slots past the count are out of range.
	task automatic test_bitmap_full();
		write_slot_count(11'd2);
		alloc_slot(32'hA5A5_A5A5);
		alloc_slot(32'h5A5A_5A5A);
		free_slot(10'd2, 32'h0000_1000);
		free_slot(10'd1023, 32'hFFFF_FFFF);
		free_slot(10'd1, 32'h0000_0200);
		alloc_slot(32'h7FFF_FFFF);
	endtask

	// No slots at all: every command is an error.
	task automatic test_zero_count();
		write_slot_count(11'd0);
		alloc_slot(32'hFFFF_FFFF);
		free_slot(10'd0, 32'hFFFF_FFFF);
	endtask

	// Counts above the maximum act as the maximum.
	task automatic test_oversize_count();
		write_slot_count(11'd2047);
		free_slot(10'd1023, 32'hDEAD_BEEF);
		alloc_slot(32'h0000_0001);
		write_slot_count(11'd1025);
		free_slot(10'd1023, 32'h0000_0000);
		free_slot(10'd0, 32'hFFFF_FFFF);
	endtask

	// Random commands under one slot count: mostly allocates and frees of
	// slots in use, with some frees of arbitrary slots mixed in.
	task automatic test_random_traffic(input int unsigned n, input logic [CFG_W-1:0] count,
			input int unsigned alloc_pct, input bit calm);
		int unsigned r;
		write_slot_count(count);
		quiet = calm;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < alloc_pct)
				alloc_slot(pick_page());
			else if (r < 90)
				free_slot(pick_held_slot(), pick_page());
			else
				free_slot(SLOT_W'($urandom), pick_page());
		end
		quiet = 1'b0;
	endtask

	// Reset, then run the tests in turn.
	initial begin
		arst_n         = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_wr_data    = '0;
		in_valid       = 1'b0;
		in_data        = '0;
		quiet          = 1'b0;
		mismatch_count = 0;
		slot_count_reg = SLOT_COUNT_RST;
		foreach (slot_taken[i])
			slot_taken[i] = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		test_first_fit();
		test_bitmap_full();
		test_zero_count();
		test_oversize_count();
		test_random_traffic(160, 11'd1024, 60, 1'b0);
		test_random_traffic(100, 11'd37, 55, 1'b0);
		test_random_traffic(30, 11'd1, 50, 1'b0);
		test_random_traffic(80, 11'd2047, 55, 1'b1);
		test_random_traffic(60, CFG_W'($urandom_range(0, 2047)), 55, 1'b0);

		drain_requests();
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
